// ----- src/sdc_pkg.sv -----
// Shared types and constants of the SiPM desaturation and calibration block.
// Used by every module under src; depends on nothing.
`default_nettype none

package sdc_pkg;

  // Fixed-point format of the photoelectron input and the layer field
  localparam int FRAC_BITS  = 8;
  localparam int LAYER_BITS = 7;

  localparam int PE_W    = 24;
  localparam int N_W     = 16;
  localparam int SCALE_W = 16;
  localparam int CAL_W   = 24;
  localparam int CFG_W   = 24;
  localparam int IDX_W   = 3;
  localparam int OUT_W   = 32;

  // Operand of the log unit: D = N << FRAC_BITS
  localparam int AW      = N_W + FRAC_BITS;
  // Threshold compare width: covers 20*x and 19*D
  localparam int CMPW    = ((AW + 5) > 29) ? (AW + 5) : 29;
  // 20*x - 19*D is below 20*2^24
  localparam int DIFF_W  = 29;

  // log2 unit: Q1.31 mantissa, one fraction bit per squaring step
  localparam int M_W       = 32;
  localparam int LOG_STEPS = 28;
  localparam int TOP_W     = 5;
  localparam int LOG_W     = TOP_W + LOG_STEPS;

  // ln2 in Q0.32, split for two narrow products
  localparam logic [15:0] LN2_HI = 16'hB172;
  localparam logic [15:0] LN2_LO = 16'h17F8;

  // Energy widths
  localparam int ELOG_W = 37;
  localparam int LINW   = DIFF_W + 16 - FRAC_BITS;
  localparam int EW     = ((LINW > ELOG_W) ? LINW : ELOG_W) + 1;
  localparam int SPLIT  = 24;

  typedef enum logic [IDX_W-1:0] {
    REG_PIXEL_COUNT     = 3'd0,
    REG_MIP_SCALE_RECIP = 3'd1,
    REG_GROUP_EDGE_LOW  = 3'd2,
    REG_GROUP_EDGE_HIGH = 3'd3,
    REG_CALIB_GROUP_0   = 3'd4,
    REG_CALIB_GROUP_1   = 3'd5,
    REG_CALIB_GROUP_2   = 3'd6
  } sdc_reg_e;

  typedef struct packed {
    logic [PE_W-1:0]       pe_amount;
    logic [LAYER_BITS-1:0] layer_number;
  } sdc_in_t;

  typedef struct packed {
    logic [OUT_W-1:0] energy_out;
    logic             linear_region;
    logic             overflow_flag;
  } sdc_out_t;

  typedef struct packed {
    logic [N_W-1:0]        pixel_count;
    logic [SCALE_W-1:0]    mip_scale_recip;
    logic [LAYER_BITS-1:0] group_edge_low;
    logic [LAYER_BITS-1:0] group_edge_high;
    logic [CAL_W-1:0]      calib_group_zero;
    logic [CAL_W-1:0]      calib_group_one;
    logic [CAL_W-1:0]      calib_group_two;
  } sdc_cfg_t;

  // Side data that travels with a word down the cell chain
  typedef struct packed {
    logic                  lin;
    logic [DIFF_W-1:0]     diff;
    logic [LAYER_BITS-1:0] layer;
    logic [TOP_W-1:0]      top_a;
    logic [TOP_W-1:0]      top_b;
  } sdc_carry_t;

  // One lane of the log2 unit
  typedef struct packed {
    logic [M_W-1:0]       m;
    logic [LOG_STEPS-1:0] frac;
  } sdc_lane_t;

endpackage

`default_nettype wire

// ----- src/sipm_desaturate_calibrate.sv -----
// SiPM desaturation and calibration: one calibrated energy word per hit word.
// An item passes 37 registers:
// two front stages, a chain of 28 squaring cells that forms the log2 fraction bits
// of both operands, six scaling stages and the output register. A new hit word is
// accepted in every cycle; the whole pipeline holds only when its last stage
// and the output register are both full and the output is not taken.
// Configuration writes are accepted in every cycle and must arrive while the
// pipeline is empty. Depends on sdc_pkg, sdc_front, sdc_log_cell, sdc_back.
`default_nettype none

module sipm_desaturate_calibrate (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire sdc_pkg::sdc_in_t             in_data_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output sdc_pkg::sdc_out_t                 out_data_o,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [sdc_pkg::IDX_W-1:0]    cfg_index_i,
  input  wire logic [sdc_pkg::CFG_W-1:0]    cfg_data_i
);

  localparam int STEPS = sdc_pkg::LOG_STEPS;
  localparam int LB    = sdc_pkg::LAYER_BITS;

  // Configuration registers
  sdc_pkg::sdc_cfg_t cfg_q;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pixel_count      <= 16'd2000;
      cfg_q.mip_scale_recip  <= 16'd6554;
      cfg_q.group_edge_low   <= LB'(20);
      cfg_q.group_edge_high  <= LB'(40);
      cfg_q.calib_group_zero <= 24'd65536;
      cfg_q.calib_group_one  <= 24'd65536;
      cfg_q.calib_group_two  <= 24'd65536;
    end else if (cfg_valid_i) begin
      unique case (sdc_pkg::sdc_reg_e'(cfg_index_i))
        sdc_pkg::REG_PIXEL_COUNT:     cfg_q.pixel_count     <= cfg_data_i[15:0];
        sdc_pkg::REG_MIP_SCALE_RECIP: cfg_q.mip_scale_recip <= cfg_data_i[15:0];
        sdc_pkg::REG_GROUP_EDGE_LOW:  cfg_q.group_edge_low  <= cfg_data_i[LB-1:0];
        sdc_pkg::REG_GROUP_EDGE_HIGH: cfg_q.group_edge_high <= cfg_data_i[LB-1:0];
        sdc_pkg::REG_CALIB_GROUP_0:   cfg_q.calib_group_zero <= cfg_data_i;
        sdc_pkg::REG_CALIB_GROUP_1:   cfg_q.calib_group_one  <= cfg_data_i;
        sdc_pkg::REG_CALIB_GROUP_2:   cfg_q.calib_group_two  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Pipeline advance: hold only when the last stage cannot drain
  logic back_valid;
  logic en;
  assign en         = !back_valid || !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // Front end
  logic                stg_valid [0:STEPS];
  sdc_pkg::sdc_carry_t stg_carry [0:STEPS];
  sdc_pkg::sdc_lane_t  stg_lane_a [0:STEPS];
  sdc_pkg::sdc_lane_t  stg_lane_b [0:STEPS];

  sdc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .valid_i       (in_valid_i),
    .data_i        (in_data_i),
    .pixel_count_i (cfg_q.pixel_count),
    .valid_o       (stg_valid[0]),
    .carry_o       (stg_carry[0]),
    .lane_a_o      (stg_lane_a[0]),
    .lane_b_o      (stg_lane_b[0])
  );

  // Chain of squaring cells, one fraction bit each
  for (genvar g = 0; g < STEPS; g++) begin : g_cell
    sdc_log_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (en),
      .valid_i  (stg_valid[g]),
      .carry_i  (stg_carry[g]),
      .lane_a_i (stg_lane_a[g]),
      .lane_b_i (stg_lane_b[g]),
      .valid_o  (stg_valid[g+1]),
      .carry_o  (stg_carry[g+1]),
      .lane_a_o (stg_lane_a[g+1]),
      .lane_b_o (stg_lane_b[g+1])
    );
  end

  // Back end
  sdc_pkg::sdc_out_t back_data;

  sdc_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (stg_valid[STEPS]),
    .carry_i  (stg_carry[STEPS]),
    .lane_a_i (stg_lane_a[STEPS]),
    .lane_b_i (stg_lane_b[STEPS]),
    .cfg_i    (cfg_q),
    .valid_o  (back_valid),
    .data_o   (back_data)
  );

  // Output register: load when empty or taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (!out_valid_o || out_ready_i) begin
      out_valid_o <= back_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_o || out_ready_i) begin
      out_data_o <= back_data;
    end
  end

  // A clipped word always reads as all ones
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.overflow_flag |-> out_data_o.energy_out == '1)
    else $error("overflow without clipped energy");

  // Input back-pressure only when a finished word is stuck at the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i && back_valid)
    else $error("input stalled without output back-pressure");

  // Zero pixel count always takes the linear branch
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && cfg_q.pixel_count == '0 |-> out_data_o.linear_region)
    else $error("log branch taken with zero pixel count");

endmodule

`default_nettype wire

// ----- src/sdc_front.sv -----
// Front end: branch decision, log operand choice and normalisation.
// Depends on sdc_pkg.
`default_nettype none

module sdc_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire logic               valid_i,
  input  wire sdc_pkg::sdc_in_t   data_i,
  input  wire logic [sdc_pkg::N_W-1:0] pixel_count_i,
  output logic                    valid_o,
  output sdc_pkg::sdc_carry_t     carry_o,
  output sdc_pkg::sdc_lane_t      lane_a_o,
  output sdc_pkg::sdc_lane_t      lane_b_o
);

  localparam int AW   = sdc_pkg::AW;
  localparam int CMPW = sdc_pkg::CMPW;

  // Index of the top set bit; zero gives zero
  function automatic logic [sdc_pkg::TOP_W-1:0] top_bit(input logic [AW-1:0] v);
    logic [sdc_pkg::TOP_W-1:0] t;
    t = '0;
    for (int i = 0; i < AW; i++) begin
      if (v[i]) t = sdc_pkg::TOP_W'(i);
    end
    return t;
  endfunction

  logic [AW-1:0]   d_val;
  logic [CMPW-1:0] x_ext, d_ext, x20, d19, diff_w, bsub;
  logic            lin;

  // Compare 20*x against 19*D and pick the two log operands
  always_comb begin
    d_val  = {pixel_count_i, {sdc_pkg::FRAC_BITS{1'b0}}};
    x_ext  = CMPW'(data_i.pe_amount);
    d_ext  = CMPW'(d_val);
    x20    = (x_ext << 4) + (x_ext << 2);
    d19    = (d_ext << 4) + (d_ext << 1) + d_ext;
    lin    = (x20 >= d19);
    diff_w = x20 - d19;
    bsub   = d_ext - x_ext;
  end

  logic                               s1_valid_q;
  logic                               s1_lin_q;
  logic [sdc_pkg::DIFF_W-1:0]         s1_diff_q;
  logic [sdc_pkg::LAYER_BITS-1:0]     s1_layer_q;
  logic [AW-1:0]                      s1_a_q, s1_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en_i) begin
      s1_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_lin_q   <= lin;
      s1_diff_q  <= diff_w[sdc_pkg::DIFF_W-1:0];
      s1_layer_q <= data_i.layer_number;
      s1_a_q     <= lin ? AW'(20) : d_val;
      s1_b_q     <= lin ? AW'(1)  : bsub[AW-1:0];
    end
  end

  // Normalise both operands to Q1.31
  logic [sdc_pkg::TOP_W-1:0] top_a, top_b;
  logic [sdc_pkg::M_W-1:0]   m_a, m_b;

  always_comb begin
    top_a = top_bit(s1_a_q);
    top_b = top_bit(s1_b_q);
    m_a   = sdc_pkg::M_W'(s1_a_q) << (sdc_pkg::TOP_W'(31) - top_a);
    m_b   = sdc_pkg::M_W'(s1_b_q) << (sdc_pkg::TOP_W'(31) - top_b);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      carry_o.lin   <= s1_lin_q;
      carry_o.diff  <= s1_diff_q;
      carry_o.layer <= s1_layer_q;
      carry_o.top_a <= top_a;
      carry_o.top_b <= top_b;
      lane_a_o.m    <= m_a;
      lane_a_o.frac <= '0;
      lane_b_o.m    <= m_b;
      lane_b_o.frac <= '0;
    end
  end

endmodule

`default_nettype wire

// ----- src/sdc_log_cell.sv -----
// One cell of the log2 chain: squares both mantissas and yields one fraction bit each.
// Depends on sdc_pkg.
`default_nettype none

module sdc_log_cell (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                en_i,
  input  wire logic                valid_i,
  input  wire sdc_pkg::sdc_carry_t carry_i,
  input  wire sdc_pkg::sdc_lane_t  lane_a_i,
  input  wire sdc_pkg::sdc_lane_t  lane_b_i,
  output logic                     valid_o,
  output sdc_pkg::sdc_carry_t      carry_o,
  output sdc_pkg::sdc_lane_t       lane_a_o,
  output sdc_pkg::sdc_lane_t       lane_b_o
);

  // m = m*m >> 31; renormalise and shift the fraction bit in
  function automatic sdc_pkg::sdc_lane_t sq_step(input sdc_pkg::sdc_lane_t l);
    logic [2*sdc_pkg::M_W-1:0] sq;
    logic [sdc_pkg::M_W:0]     t;
    sdc_pkg::sdc_lane_t        r;
    sq     = (2*sdc_pkg::M_W)'(l.m) * (2*sdc_pkg::M_W)'(l.m);
    t      = sq[2*sdc_pkg::M_W-1:sdc_pkg::M_W-1];
    r.m    = t[sdc_pkg::M_W] ? t[sdc_pkg::M_W:1] : t[sdc_pkg::M_W-1:0];
    r.frac = {l.frac[sdc_pkg::LOG_STEPS-2:0], t[sdc_pkg::M_W]};
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      carry_o  <= carry_i;
      lane_a_o <= sq_step(lane_a_i);
      lane_b_o <= sq_step(lane_b_i);
    end
  end

endmodule

`default_nettype wire

// ----- src/sdc_back.sv -----
// Back end: log difference to N*ln, linear branch, MIP scaling, group calibration, clipping.
// Depends on sdc_pkg.
`default_nettype none

module sdc_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                en_i,
  input  wire logic                valid_i,
  input  wire sdc_pkg::sdc_carry_t carry_i,
  input  wire sdc_pkg::sdc_lane_t  lane_a_i,
  input  wire sdc_pkg::sdc_lane_t  lane_b_i,
  input  wire sdc_pkg::sdc_cfg_t   cfg_i,
  output logic                     valid_o,
  output sdc_pkg::sdc_out_t        data_o
);

  localparam int LOG_W = sdc_pkg::LOG_W;
  localparam int EW    = sdc_pkg::EW;
  localparam int SPLIT = sdc_pkg::SPLIT;
  localparam int PV_W  = LOG_W + 16;
  localparam int LB    = sdc_pkg::LAYER_BITS;

  logic [6:1] vld_q;

  // Advance the stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[5:1], valid_i};
    end
  end
  assign valid_o = vld_q[6];

  // Stage 1: v = L(a) - L(b), times ln2 in two halves
  logic [LOG_W-1:0] la, lb, v;
  always_comb begin
    la = {carry_i.top_a, lane_a_i.frac};
    lb = {carry_i.top_b, lane_b_i.frac};
    v  = (la > lb) ? (la - lb) : '0;
  end

  logic                       b1_lin_q, b2_lin_q, b3_lin_q, b4_lin_q, b5_lin_q;
  logic [sdc_pkg::DIFF_W-1:0] b1_diff_q, b2_diff_q;
  logic [LB-1:0]              b1_layer_q, b2_layer_q, b3_layer_q, b4_layer_q, b5_layer_q;
  logic [PV_W-1:0]            b1_ph_q, b1_pl_q;
  logic [LOG_W-1:0]           b2_w_q;
  logic [EW-1:0]              b3_e_q;
  logic [SPLIT+15:0]          b4_pl_q;
  logic [EW-SPLIT+15:0]       b4_ph_q;
  logic [EW-1:0]              b5_m_q;
  logic [SPLIT+sdc_pkg::CAL_W-1:0] b6_pl_q;
  logic [EW-SPLIT+sdc_pkg::CAL_W-1:0] b6_ph_q;
  logic                       b6_lin_q;

  // Stage 2: w = (v*ln2) >> 32
  logic [PV_W+16:0] vsum;
  assign vsum = ((PV_W+17)'(b1_ph_q) << 16) + (PV_W+17)'(b1_pl_q);

  // Stage 3: E = N*w >> 12, plus the linear part
  logic [LOG_W+sdc_pkg::N_W-1:0] nw;
  logic [EW-1:0]                 lin_e, elog_e;
  always_comb begin
    nw     = (LOG_W+sdc_pkg::N_W)'(cfg_i.pixel_count) * (LOG_W+sdc_pkg::N_W)'(b2_w_q);
    elog_e = EW'(nw[LOG_W+sdc_pkg::N_W-1:12]);
    lin_e  = EW'(b2_diff_q) << (16 - sdc_pkg::FRAC_BITS);
  end

  // Stage 5: recombine E*recip and drop 16 bits
  logic [EW+15:0] eprod;
  assign eprod = ((EW+16)'(b4_ph_q) << SPLIT) + (EW+16)'(b4_pl_q);

  // Stage 6: pick the layer group factor
  logic [sdc_pkg::CAL_W-1:0] calib;
  always_comb begin
    priority if (b5_layer_q < cfg_i.group_edge_low) begin
      calib = cfg_i.calib_group_zero;
    end else if (b5_layer_q < cfg_i.group_edge_high) begin
      calib = cfg_i.calib_group_one;
    end else begin
      calib = cfg_i.calib_group_two;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b1_lin_q   <= carry_i.lin;
      b1_diff_q  <= carry_i.diff;
      b1_layer_q <= carry_i.layer;
      b1_ph_q    <= PV_W'(v) * PV_W'(sdc_pkg::LN2_HI);
      b1_pl_q    <= PV_W'(v) * PV_W'(sdc_pkg::LN2_LO);

      b2_lin_q   <= b1_lin_q;
      b2_diff_q  <= b1_diff_q;
      b2_layer_q <= b1_layer_q;
      b2_w_q     <= vsum[LOG_W+31:32];

      b3_lin_q   <= b2_lin_q;
      b3_layer_q <= b2_layer_q;
      b3_e_q     <= b2_lin_q ? (lin_e + elog_e) : elog_e;

      b4_lin_q   <= b3_lin_q;
      b4_layer_q <= b3_layer_q;
      b4_pl_q    <= (SPLIT+16)'(b3_e_q[SPLIT-1:0]) * (SPLIT+16)'(cfg_i.mip_scale_recip);
      b4_ph_q    <= (EW-SPLIT+16)'(b3_e_q[EW-1:SPLIT]) * (EW-SPLIT+16)'(cfg_i.mip_scale_recip);

      b5_lin_q   <= b4_lin_q;
      b5_layer_q <= b4_layer_q;
      b5_m_q     <= eprod[EW+15:16];

      b6_lin_q   <= b5_lin_q;
      b6_pl_q    <= (SPLIT+sdc_pkg::CAL_W)'(b5_m_q[SPLIT-1:0])
                    * (SPLIT+sdc_pkg::CAL_W)'(calib);
      b6_ph_q    <= (EW-SPLIT+sdc_pkg::CAL_W)'(b5_m_q[EW-1:SPLIT])
                    * (EW-SPLIT+sdc_pkg::CAL_W)'(calib);
    end
  end

  // Stage 7: recombine M*calib, drop 16 bits and clip to 32
  logic [EW+sdc_pkg::CAL_W-1:0] eng;
  logic                         over;
  always_comb begin
    eng  = ((EW+sdc_pkg::CAL_W)'(b6_ph_q) << SPLIT) + (EW+sdc_pkg::CAL_W)'(b6_pl_q);
    over = |eng[EW+sdc_pkg::CAL_W-1:48];
    data_o.energy_out    = over ? '1 : eng[47:16];
    data_o.linear_region = b6_lin_q;
    data_o.overflow_flag = over;
  end

endmodule

`default_nettype wire

// ----- dv/sdc_checker.sv -----
// Checker of the SiPM desaturation and calibration block: watches the hit,
// result and register channels, predicts each energy word and compares it.
// Depends on sdc_pkg.
`timescale 1ns / 1ps

module sdc_checker (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              in_ready_i,
  input  wire sdc_pkg::sdc_in_t  in_data_i,
  input  wire logic              out_valid_i,
  input  wire logic              out_ready_i,
  input  wire sdc_pkg::sdc_out_t out_data_i,
  input  wire logic              cfg_valid_i,
  input  wire logic              cfg_ready_i,
  input  wire logic [sdc_pkg::IDX_W-1:0] cfg_index_i,
  input  wire logic [sdc_pkg::CFG_W-1:0] cfg_data_i,
  output int                     fail_count_o,
  output int                     pending_o,
  output int                     checked_o
);
  import sdc_pkg::*;

  localparam logic [63:0] LN2_Q32 = 64'hB17217F8;

  sdc_cfg_t regs_q;
  sdc_out_t energy_q[$];

  // log2 of a positive integer, six integer and 28 fraction bits
  function automatic logic [63:0] log2_fix(logic [63:0] a);
    int top;
    logic [63:0] m;
    logic [63:0] frac;
    if (a == 0) return 64'd0;
    top = 63;
    while (!a[top]) top--;
    if (top >= 31) m = a >> (top - 31);
    else m = a << (31 - top);
    frac = 0;
    for (int i = 0; i < 28; i++) begin
      m = (m * m) >> 31;
      frac = frac << 1;
      if (m >= 64'h1_0000_0000) begin
        frac = frac | 64'd1;
        m = m >> 1;
      end
    end
    return (64'(top) << 28) | frac;
  endfunction

  // pixel count times the natural log of a log2 value, in Q.16
  function automatic logic [63:0] pixels_ln(logic [63:0] n, logic [63:0] v);
    logic [63:0] w;
    logic [63:0] p;
    p = v * LN2_Q32;
    w = p >> 32;
    p = n * w;
    return p >> 12;
  endfunction

  function automatic sdc_out_t calibrate_hit(sdc_in_t hit, sdc_cfg_t c);
    logic [63:0] x, n, d, e, la, lb, v, mip, calib, en;
    logic [127:0] prod;
    sdc_out_t r;
    x = 64'(hit.pe_amount);
    n = 64'(c.pixel_count);
    d = n << FRAC_BITS;
    r.linear_region = !(20 * x < 19 * d);
    r.overflow_flag = 1'b0;
    if (!r.linear_region) begin
      la = log2_fix(d);
      lb = log2_fix(d - x);
      v = (la > lb) ? la - lb : 64'd0;
      e = pixels_ln(n, v);
    end else begin
      e = ((20 * x - 19 * d) << (16 - FRAC_BITS)) + pixels_ln(n, log2_fix(64'd20));
    end
    mip = (e * 64'(c.mip_scale_recip)) >> 16;
    if (hit.layer_number < c.group_edge_low) calib = 64'(c.calib_group_zero);
    else if (hit.layer_number < c.group_edge_high) calib = 64'(c.calib_group_one);
    else calib = 64'(c.calib_group_two);
    prod = 128'(mip) * 128'(calib);
    en = prod[79:16];
    if (prod[127:64] != 0 || en > 64'hFFFF_FFFF) begin
      r.overflow_flag = 1'b1;
      r.energy_out = 32'hFFFF_FFFF;
    end else begin
      r.energy_out = en[31:0];
    end
    return r;
  endfunction

  assign pending_o = energy_q.size();

  // Track registers, queue predictions and compare results
  always @(posedge clk_i or negedge rst_ni) begin
    sdc_out_t exp_w;
    if (!rst_ni) begin
      regs_q <= '{pixel_count: 16'd2000, mip_scale_recip: 16'd6554,
                  group_edge_low: 7'd20, group_edge_high: 7'd40,
                  calib_group_zero: 24'd65536, calib_group_one: 24'd65536,
                  calib_group_two: 24'd65536};
      energy_q.delete();
      fail_count_o <= 0;
      checked_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (sdc_reg_e'(cfg_index_i))
          REG_PIXEL_COUNT:     regs_q.pixel_count <= cfg_data_i[N_W-1:0];
          REG_MIP_SCALE_RECIP: regs_q.mip_scale_recip <= cfg_data_i[SCALE_W-1:0];
          REG_GROUP_EDGE_LOW:  regs_q.group_edge_low <= cfg_data_i[LAYER_BITS-1:0];
          REG_GROUP_EDGE_HIGH: regs_q.group_edge_high <= cfg_data_i[LAYER_BITS-1:0];
          REG_CALIB_GROUP_0:   regs_q.calib_group_zero <= cfg_data_i[CAL_W-1:0];
          REG_CALIB_GROUP_1:   regs_q.calib_group_one <= cfg_data_i[CAL_W-1:0];
          REG_CALIB_GROUP_2:   regs_q.calib_group_two <= cfg_data_i[CAL_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) energy_q.push_back(calibrate_hit(in_data_i, regs_q));
      if (out_valid_i && out_ready_i) begin
        checked_o <= checked_o + 1;
        if (energy_q.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual %h", $time, out_data_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_w = energy_q.pop_front();
          if (exp_w.energy_out !== out_data_i.energy_out) begin
            $display("%0t: energy_out expected %h actual %h", $time,
                     exp_w.energy_out, out_data_i.energy_out);
            fail_count_o <= fail_count_o + 1;
          end else if (exp_w.linear_region !== out_data_i.linear_region) begin
            $display("%0t: linear_region expected %b actual %b", $time,
                     exp_w.linear_region, out_data_i.linear_region);
            fail_count_o <= fail_count_o + 1;
          end else if (exp_w.overflow_flag !== out_data_i.overflow_flag) begin
            $display("%0t: overflow_flag expected %b actual %b", $time,
                     exp_w.overflow_flag, out_data_i.overflow_flag);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

endmodule

// ----- dv/tb_sipm_desaturate_calibrate.sv -----
// Testbench top of the SiPM desaturation and calibration block: drives hits under
// random idling and register writes, gives the verdict.
// Depends on sdc_pkg, sipm_desaturate_calibrate and sdc_checker.
`timescale 1ns / 1ps

module tb_sipm_desaturate_calibrate;
  import sdc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  sdc_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  sdc_out_t out_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;
  int fail_count, pending, checked;
  int cycles = 0;
  int hits_sent = 0;
  int settings_run = 0;
  bit calm = 1'b0;
  logic [15:0] pixels_q = 16'd2000;

  sipm_desaturate_calibrate uut (.*);

  sdc_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_data_i(out_data_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending), .checked_o(checked)
  );

  always #6 clk_i = ~clk_i;

  // Stall the result side at random, except in the calm stretch
  always @(posedge clk_i) begin
    if (calm) out_ready_i <= 1'b1;
    else out_ready_i <= ($urandom_range(0, 99) >= 11);
  end

  // Cycle limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Send one hit word; valid stays high across back-to-back words
  task automatic send_hit(logic [23:0] pe, logic [6:0] layer);
    if (!calm && $urandom_range(0, 99) < 11) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= '{pe_amount: pe, layer_number: layer};
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    hits_sent++;
  endtask

  // Drain the pipeline, then hold while it empties fully
  task automatic drain_pipe();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (45) @(posedge clk_i);
  endtask

  // Write one register; valid stays high across back-to-back writes
  task automatic write_reg(sdc_reg_e idx, logic [23:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == REG_PIXEL_COUNT) pixels_q = value[15:0];
  endtask

  task automatic load_setting(logic [15:0] n, logic [15:0] scale, logic [6:0] lo,
                              logic [6:0] hi, logic [23:0] c0, logic [23:0] c1,
                              logic [23:0] c2);
    drain_pipe();
    write_reg(REG_PIXEL_COUNT, {8'd0, n});
    write_reg(REG_MIP_SCALE_RECIP, {8'd0, scale});
    write_reg(REG_GROUP_EDGE_LOW, {17'd0, lo});
    write_reg(REG_GROUP_EDGE_HIGH, {17'd0, hi});
    write_reg(REG_CALIB_GROUP_0, c0);
    write_reg(REG_CALIB_GROUP_1, c1);
    write_reg(REG_CALIB_GROUP_2, c2);
    cfg_valid_i <= 1'b0;
    settings_run++;
  endtask

  // Half the counts around the saturation range, the rest small or over the full field
  task automatic random_hits(int count);
    logic [31:0] d;
    logic [23:0] pe;
    d = {8'd0, pixels_q, 8'd0};
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 3))
        0: pe = 24'($urandom);
        1: pe = 24'($urandom_range(0, 255));
        2: pe = 24'((d * 19 / 20) + $urandom_range(0, 8) - 4);
        default: pe = (d == 0) ? 24'($urandom) : 24'($urandom_range(0, d * 21 / 20));
      endcase
      send_hit(pe, 7'($urandom));
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: threshold edges, field extremes and group boundaries
    load_setting(16'd2000, 16'd6554, 7'd20, 7'd40, 24'd65536, 24'd65536, 24'd65536);
    send_hit(24'd0, 7'd0);
    send_hit(24'hFFFFFF, 7'd127);
    send_hit(24'd486399, 7'd19);
    send_hit(24'd486400, 7'd20);
    send_hit(24'd486401, 7'd39);
    send_hit(24'd1, 7'd40);
    send_hit(24'd511999, 7'd85);
    // Zero pixel count always takes the linear branch
    load_setting(16'd0, 16'hFFFF, 7'd127, 7'd0, 24'hFFFFFF, 24'd1, 24'h800000);
    send_hit(24'd0, 7'd0);
    send_hit(24'hFFFFFF, 7'd126);
    send_hit(24'h800000, 7'd127);
    // Zero scale and zero calibration give zero energy
    load_setting(16'd65535, 16'd0, 7'd0, 7'd127, 24'd0, 24'd0, 24'd0);
    send_hit(24'hFFFFFF, 7'd5);
    send_hit(24'h123456, 7'd127);
    // Overflow with the largest scale and calibration
    load_setting(16'd1, 16'hFFFF, 7'd64, 7'd64, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    send_hit(24'hFFFFFF, 7'd0);
    send_hit(24'd243, 7'd127);
    send_hit(24'd0, 7'd63);

    // Random phases over several register settings, one of them calm
    load_setting(16'd2000, 16'd6554, 7'd20, 7'd40, 24'd65536, 24'd65536, 24'd65536);
    random_hits(150);
    load_setting(16'd65535, 16'hFFFF, 7'd0, 7'd127, 24'hFFFFFF, 24'h00FFFF, 24'd1);
    random_hits(150);
    load_setting(16'd1, 16'd1, 7'd127, 7'd127, 24'd0, 24'hABCDEF, 24'hFFFFFF);
    random_hits(150);
    calm = 1'b1;
    load_setting(16'($urandom), 16'($urandom), 7'($urandom), 7'($urandom),
                 24'($urandom), 24'($urandom), 24'($urandom));
    random_hits(150);
    calm = 1'b0;
    for (int k = 0; k < 4; k++) begin
      load_setting(16'($urandom_range(1, 4000)), 16'($urandom), 7'($urandom),
                   7'($urandom), 24'($urandom_range(0, 24'h3FFFF)), 24'($urandom),
                   24'($urandom_range(0, 24'h1FFFF)));
      random_hits(150);
    end

    drain_pipe();
    $display("Sent %0d hit words over %0d register settings, %0d results checked",
             hits_sent, settings_run, checked);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
